FILE: src/h2r_pkg.sv
// Shared types, constants and helpers for the HSV to RGB pixel pipeline.
package h2r_pkg;

  // Field widths
  localparam int HueW = 9;
  localparam int PctW = 7;
  localparam int ChW  = 8;
  localparam int FracW = 6;
  localparam int XW   = 13;

  // Scaled numerator v*x and its reduced form (v*x*17)>>6
  localparam int MW   = 20;
  localparam int M17W = 24;
  localparam int ZW   = 18;

  // Reciprocal of 625 as 2^28 / 625, rounded up; exact for z below 2^18
  localparam int RecipW     = 19;
  localparam int RecipShift = 28;
  localparam int ProdW      = ZW + RecipW;
  localparam logic [RecipW-1:0] Recip625 = 19'd429497;

  // Pipeline depth: reduce, lane terms, multiply, scale, divide, select
  localparam int NumStages = 6;

  // Arithmetic constants
  localparam logic [HueW-1:0]  HueTurn    = 9'd360;
  localparam logic [PctW-1:0]  PctMax     = 7'd100;
  localparam logic [FracW-1:0] SectorSpan = 6'd60;
  localparam logic [XW-1:0]    XFull      = 13'd6000;

  // Lanes: every channel value is floor(v * x * 255 / 600000)
  localparam int NumLanes = 4;
  localparam int LaneFull = 0;
  localparam int LaneP    = 1;
  localparam int LaneQ    = 2;
  localparam int LaneT    = 3;

  typedef enum logic [2:0] {
    SecRedYel  = 3'd0,
    SecYelGrn  = 3'd1,
    SecGrnCyan = 3'd2,
    SecCyanBlu = 3'd3,
    SecBluMag  = 3'd4,
    SecMagRed  = 3'd5
  } h2r_sector_e;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] saturation;
    logic [PctW-1:0] value;
  } h2r_in_t;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } h2r_out_t;

  typedef logic [NumLanes-1:0][XW-1:0]  h2r_lanes_x_t;
  typedef logic [NumLanes-1:0][ChW-1:0] h2r_lanes_ch_t;

  // First hue of each sector
  function automatic logic [HueW-1:0] sector_base(input h2r_sector_e sec);
    logic [HueW-1:0] base;
    unique case (sec)
      SecRedYel:  base = 9'd0;
      SecYelGrn:  base = 9'd60;
      SecGrnCyan: base = 9'd120;
      SecCyanBlu: base = 9'd180;
      SecBluMag:  base = 9'd240;
      SecMagRed:  base = 9'd300;
      default:    base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

FILE: src/h2r_front.sv
// Front stages: hue reduction, sector split and per-lane numerator terms.
module h2r_front (
  input  logic                  clk_i,
  input  logic [1:0]            en_i,
  input  h2r_pkg::h2r_in_t      in_i,
  output h2r_pkg::h2r_sector_e  sector_o,
  output logic [h2r_pkg::PctW-1:0] v_o,
  output h2r_pkg::h2r_lanes_x_t x_o
);
  import h2r_pkg::*;

  logic [HueW-1:0]  hue_red;
  h2r_sector_e      sec_d, sec1_q, sec2_q;
  logic [FracW-1:0] frac_d, frac1_q;
  logic [PctW-1:0]  s_d, s1_q, v_d, v1_q, v2_q;
  logic [FracW-1:0] k_t;
  h2r_lanes_x_t     x_d, x_q;

  // Wrap hue into 0..359, find the sector and the offset within it; clamp s and v to 100
  always_comb begin
    hue_red = (in_i.hue >= HueTurn) ? in_i.hue - HueTurn : in_i.hue;
    if (hue_red >= 9'd300)      sec_d = SecMagRed;
    else if (hue_red >= 9'd240) sec_d = SecBluMag;
    else if (hue_red >= 9'd180) sec_d = SecCyanBlu;
    else if (hue_red >= 9'd120) sec_d = SecGrnCyan;
    else if (hue_red >= 9'd60)  sec_d = SecYelGrn;
    else                        sec_d = SecRedYel;
    frac_d = FracW'(hue_red - sector_base(sec_d));
    s_d    = (in_i.saturation > PctMax) ? PctMax : in_i.saturation;
    v_d    = (in_i.value > PctMax) ? PctMax : in_i.value;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sec1_q  <= sec_d;
      frac1_q <= frac_d;
      s1_q    <= s_d;
      v1_q    <= v_d;
    end
  end

  // Form x = 6000 - s*k for each lane: k is 0, 60, f or 60-f
  always_comb begin
    k_t            = SectorSpan - frac1_q;
    x_d[LaneFull]  = XFull;
    x_d[LaneP]     = XFull - XW'(s1_q) * XW'(SectorSpan);
    x_d[LaneQ]     = XFull - XW'(s1_q) * XW'(frac1_q);
    x_d[LaneT]     = XFull - XW'(s1_q) * XW'(k_t);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sec2_q <= sec1_q;
      v2_q   <= v1_q;
      x_q    <= x_d;
    end
  end

  assign sector_o = sec2_q;
  assign v_o      = v2_q;
  assign x_o      = x_q;

endmodule

FILE: src/h2r_scale.sv
// One channel lane: floor(v * x * 255 / 600000) over three register stages.
module h2r_scale (
  input  logic                      clk_i,
  input  logic [2:0]                en_i,
  input  logic [h2r_pkg::PctW-1:0]  v_i,
  input  logic [h2r_pkg::XW-1:0]    x_i,
  output logic [h2r_pkg::ChW-1:0]   ch_o
);
  import h2r_pkg::*;

  logic [MW-1:0]   m_d, m_q;
  logic [M17W-1:0] m17;
  logic [ZW-1:0]   z_d, z_q;
  logic [ProdW-1:0] prod;
  logic [ChW-1:0]  ch_d, ch_q;

  // 255/600000 = 17/40000 = 17 / (64 * 625)
  assign m_d  = MW'(v_i) * MW'(x_i);
  assign m17  = {m_q, 4'b0000} + M17W'(m_q);
  assign z_d  = m17[M17W-1:M17W-ZW];
  assign prod = ProdW'(z_q) * ProdW'(Recip625);
  assign ch_d = prod[RecipShift+ChW-1:RecipShift];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) m_q  <= m_d;
    if (en_i[1]) z_q  <= z_d;
    if (en_i[2]) ch_q <= ch_d;
  end

  assign ch_o = ch_q;

endmodule

FILE: src/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter, six-stage pipeline.
// Throughput: one pixel per cycle; each stage holds under stall and fills bubbles.
// Reset clears the stage valid bits only; data registers are not reset.
module hsv_to_rgb_pixel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  h2r_pkg::h2r_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output h2r_pkg::h2r_out_t out_o
);
  import h2r_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;
  h2r_sector_e          sec2, sec3_q, sec4_q, sec5_q;
  logic [PctW-1:0]      v2;
  h2r_lanes_x_t         x2;
  h2r_lanes_ch_t        ch5;
  h2r_out_t             out_d, out_q;

  // Stage advances when empty or when the stage after it advances
  always_comb begin
    ready[NumStages] = !out_stall_i;
    for (int i = NumStages - 1; i >= 0; i--) begin
      ready[i] = !valid_q[i] || ready[i+1];
    end
  end

  assign in_stall_o = !ready[0];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      for (int i = 1; i < NumStages; i++) begin
        if (ready[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  h2r_front u_front (
    .clk_i    (clk_i),
    .en_i     (ready[1:0]),
    .in_i     (in_i),
    .sector_o (sec2),
    .v_o      (v2),
    .x_o      (x2)
  );

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    h2r_scale u_scale (
      .clk_i (clk_i),
      .en_i  (ready[4:2]),
      .v_i   (v2),
      .x_i   (x2[l]),
      .ch_o  (ch5[l])
    );
  end

  // Carry the sector alongside the lane stages
  always_ff @(posedge clk_i) begin
    if (ready[2]) sec3_q <= sec2;
    if (ready[3]) sec4_q <= sec3_q;
    if (ready[4]) sec5_q <= sec4_q;
  end

  // Route lanes to channels by sector
  always_comb begin
    unique case (sec5_q)
      SecRedYel: begin
        out_d.red = ch5[LaneFull]; out_d.green = ch5[LaneT]; out_d.blue = ch5[LaneP];
      end
      SecYelGrn: begin
        out_d.red = ch5[LaneQ]; out_d.green = ch5[LaneFull]; out_d.blue = ch5[LaneP];
      end
      SecGrnCyan: begin
        out_d.red = ch5[LaneP]; out_d.green = ch5[LaneFull]; out_d.blue = ch5[LaneT];
      end
      SecCyanBlu: begin
        out_d.red = ch5[LaneP]; out_d.green = ch5[LaneQ]; out_d.blue = ch5[LaneFull];
      end
      SecBluMag: begin
        out_d.red = ch5[LaneT]; out_d.green = ch5[LaneP]; out_d.blue = ch5[LaneFull];
      end
      default: begin
        out_d.red = ch5[LaneFull]; out_d.green = ch5[LaneP]; out_d.blue = ch5[LaneQ];
      end
    endcase
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (ready[5]) out_q <= out_d;
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign out_o       = out_q;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the HSV to RGB pixel converter.
`timescale 1ns / 100ps

module tb_top;
  import h2r_pkg::*;

  localparam int unsigned DegTurn     = 360;
  localparam int unsigned DegSector   = 60;
  localparam int unsigned Percent     = 100;
  localparam int unsigned ChanScale   = 255;
  localparam int          RandPixels  = 800;
  localparam int          QuietPixels = 200;
  localparam int          HoldOffLen  = 60;
  localparam int          StallLimit  = 1000;
  localparam int          PrintLimit  = 40;

  // One pixel in flight with the color it must come out as
  typedef struct {
    h2r_in_t  pix;
    h2r_out_t rgb;
  } rgb_due_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid = 1'b0;
  h2r_in_t  in_pix = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  h2r_out_t out_rgb;

  rgb_due_t pending_rgb[$];
  int       mismatches = 0;
  int       pixels_sent = 0;
  int       pixels_checked = 0;
  int       input_stall_cycles = 0;
  int       quiet_cycles = 0;
  int       hold_off_req = 0;
  int       rx_hold = 0;
  bit       tx_idle_en = 1'b0;
  bit       rx_idle_en = 1'b0;

  hsv_to_rgb_pixel i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_pix),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_rgb)
  );

  always #5 clk = ~clk;

  // Compute the color one pixel must convert to
  function automatic h2r_out_t predict_rgb(input h2r_in_t px);
    int unsigned hue, sat, val, full, frac, p, q, t;
    h2r_sector_e sec;
    h2r_out_t    rgb;
    hue  = px.hue % DegTurn;
    sat  = (px.saturation > Percent) ? Percent : px.saturation;
    val  = (px.value > Percent) ? Percent : px.value;
    full = (val * ChanScale) / Percent;
    if (sat == 0) begin
      rgb.red   = full[7:0];
      rgb.green = full[7:0];
      rgb.blue  = full[7:0];
    end else begin
      sec  = h2r_sector_e'(hue / DegSector);
      frac = hue % DegSector;
      p = (val * (Percent - sat) * ChanScale) / (Percent * Percent);
      q = (val * (Percent * DegSector - sat * frac) * ChanScale) /
          (Percent * Percent * DegSector);
      t = (val * (Percent * DegSector - sat * (DegSector - frac)) * ChanScale) /
          (Percent * Percent * DegSector);
      case (sec)
        SecRedYel: begin
          rgb = {full[7:0], t[7:0], p[7:0]};
        end
        SecYelGrn: begin
          rgb = {q[7:0], full[7:0], p[7:0]};
        end
        SecGrnCyan: begin
          rgb = {p[7:0], full[7:0], t[7:0]};
        end
        SecCyanBlu: begin
          rgb = {p[7:0], q[7:0], full[7:0]};
        end
        SecBluMag: begin
          rgb = {t[7:0], p[7:0], full[7:0]};
        end
        default: begin
          rgb = {full[7:0], p[7:0], q[7:0]};
        end
      endcase
    end
    return rgb;
  endfunction

  // Print one line per mismatch, for the first PrintLimit of them, and count every one
  task automatic report_mismatch(input string msg);
    if (mismatches < PrintLimit) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Offer one pixel, with an optional idle burst ahead of it, and wait for the transfer
  task automatic send_pixel(input logic [HueW-1:0] hue, input logic [PctW-1:0] sat,
                            input logic [PctW-1:0] val);
    rgb_due_t due;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    due.pix = '{hue: hue, saturation: sat, value: val};
    due.rgb = predict_rgb(due.pix);
    in_valid <= 1'b1;
    in_pix   <= due.pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_rgb.push_back(due);
    pixels_sent++;
  endtask

  // Drop valid once the stream is done
  task automatic end_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Zero saturation gives grey at the value level, whatever the hue
  task automatic test_grey();
    send_pixel(9'd0,   7'd0, 7'd0);
    send_pixel(9'd200, 7'd0, 7'd50);
    send_pixel(9'd359, 7'd0, 7'd100);
    send_pixel(9'd511, 7'd0, 7'd127);
  endtask

  // First and last hue of each of the six sectors at full saturation
  task automatic test_sector_edges();
    for (int sec = 0; sec < 6; sec++) begin
      send_pixel(9'(sec * DegSector), 7'd100, 7'd100);
      send_pixel(9'(sec * DegSector + DegSector - 1), 7'd100, 7'd87);
    end
  endtask

  // Hues from 360 up wrap around the circle
  task automatic test_hue_wrap();
    send_pixel(9'd360, 7'd73, 7'd88);
    send_pixel(9'd419, 7'd73, 7'd88);
    send_pixel(9'd511, 7'd1,  7'd99);
  endtask

  // Saturation and value above 100 percent clamp to 100
  task automatic test_percent_clamp();
    send_pixel(9'd30,  7'd101, 7'd64);
    send_pixel(9'd150, 7'd127, 7'd100);
    send_pixel(9'd270, 7'd45,  7'd101);
    send_pixel(9'd330, 7'd127, 7'd127);
  endtask

  // Hold the output off for a long stretch so the pipeline fills and stalls its input
  task automatic test_backpressure();
    tx_idle_en   = 1'b0;
    rx_idle_en   = 1'b0;
    hold_off_req = HoldOffLen;
    for (int n = 0; n < 40; n++) begin
      send_pixel(9'($urandom_range(0, 511)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)));
    end
  endtask

  // Random pixels, mostly in range, with idling switched per block; quiet at the end
  task automatic test_random();
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat, val;
    for (int n = 0; n < RandPixels; n++) begin
      if (n % 50 == 0) begin
        tx_idle_en = (n < RandPixels - QuietPixels) && ($urandom_range(0, 2) != 0);
        rx_idle_en = (n < RandPixels - QuietPixels) && ($urandom_range(0, 2) != 0);
      end
      hue = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                        : 9'($urandom_range(0, 359));
      case ($urandom_range(0, 9))
        0:       sat = '0;
        1:       sat = 7'($urandom_range(101, 127));
        default: sat = 7'($urandom_range(1, 100));
      endcase
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = 7'($urandom_range(101, 127));
        default: val = 7'($urandom_range(0, 100));
      endcase
      send_pixel(hue, sat, val);
    end
  endtask

  // Receiver stall: long hold-off on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_off_req != 0) begin
      rx_hold      = hold_off_req;
      hold_off_req = 0;
    end
    if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      rx_hold = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each result transfer against the oldest pending color
  always @(posedge clk) begin : check_rgb
    rgb_due_t due;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_rgb.size() == 0) begin
        report_mismatch($sformatf("result %0h with no pixel pending", out_rgb));
      end else begin
        due = pending_rgb.pop_front();
        pixels_checked++;
        if (out_rgb.red !== due.rgb.red)
          report_mismatch($sformatf("h=%0d s=%0d v=%0d red %0d, want %0d",
            due.pix.hue, due.pix.saturation, due.pix.value, out_rgb.red, due.rgb.red));
        if (out_rgb.green !== due.rgb.green)
          report_mismatch($sformatf("h=%0d s=%0d v=%0d green %0d, want %0d",
            due.pix.hue, due.pix.saturation, due.pix.value, out_rgb.green, due.rgb.green));
        if (out_rgb.blue !== due.rgb.blue)
          report_mismatch($sformatf("h=%0d s=%0d v=%0d blue %0d, want %0d",
            due.pix.hue, due.pix.saturation, due.pix.value, out_rgb.blue, due.rgb.blue));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (in_valid && in_stall === 1'b1) begin
      input_stall_cycles++;
    end
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d pixels pending",
               quiet_cycles, pending_rgb.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_grey();
    test_sector_edges();
    test_hue_wrap();
    test_percent_clamp();
    test_backpressure();
    test_random();
    end_stream();

    // Drain the pipeline, then wait on so that any stray results would show
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (NumStages + 4) @(posedge clk);

    $display("Converted %0d pixels, %0d checked: grey, six sector edges, hue wrap, clamping.",
             pixels_sent, pixels_checked);
    $display("Random traffic with idle bursts and a long output hold-off (%0d input stalls).",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/h2r_pkg.sv
src/h2r_front.sv
src/h2r_scale.sv
src/hsv_to_rgb_pixel.sv
sim/tb_top.sv
